FILE: src/rmq_pkg.sv
// ============================================================================
// rmq_pkg: shared types, widths and constants for the rotation matrix to
// quaternion block.
// ============================================================================
package rmq_pkg;

   localparam int QW       = 16;          // Q2.14 field width
   localparam int RAD_W    = 19;          // radicand, up to about 3*32768+16384
   localparam int ROOT_W   = 15;          // half root, at most about 21674
   localparam int DIF_W    = 17;          // sum or difference of two entries
   localparam int NUM_W    = DIF_W + 13;  // twice magnitude times 4096 plus root
   localparam int QUO_W    = NUM_W;       // raw quotient width
   localparam int Q_ONE    = 16384;
   localparam int DEF_ROOT_CELLS = ROOT_W;
   localparam int DEF_DIV_CELLS  = QUO_W;

   // per-item payload carried down the cell chain
   typedef struct packed {
      logic [ROOT_W-1:0]       root;     // half root being built
      logic [2*ROOT_W+1:0]     rem;      // root remainder
      logic [2*ROOT_W-1:0]     radx;     // radicand * 4096, shifted out
      logic [1:0]              diag;     // 0..2: x,y,z side; 3: w side
      logic                    deg;
      logic [2:0][DIF_W-1:0]   dif;      // numerators in result order
   } root_item_type;

   typedef struct packed {
      logic [QUO_W-1:0]        quo;
      logic [NUM_W:0]          rem;
      logic [NUM_W-1:0]        num;
   } div_lane_type;

   typedef struct packed {
      logic [ROOT_W-1:0]       root;
      logic [1:0]              diag;
      logic                    deg;
      logic [2:0]              neg;
      div_lane_type [2:0]      lane;
   } div_item_type;

endpackage

FILE: src/rotation_matrix_to_quaternion_top.sv
// ============================================================================
// rotation_matrix_to_quaternion_top: 3x3 rotation matrix to quaternion, Q2.14
// Shoemake branch select, cell-chain square root and divide.
// ============================================================================
//   channel | ports                    | direction
//   req     | req_valid/stall, r00-r22 | in
//   rsp     | rsp_valid/stall, qw-qz,  | out
//           | degenerate               |
// One item per cycle sustained while rsp_stall is low. Stages: front, one root
// cell per root bit, divide setup, one divide cell per quotient bit, output.
// The whole chain advances together; rsp_stall holds every stage.
// Synchronous reset clears the valid bits only.
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [QW-1:0]  req_r00, req_r01, req_r02,
   input  logic signed [QW-1:0]  req_r10, req_r11, req_r12,
   input  logic signed [QW-1:0]  req_r20, req_r21, req_r22,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [QW-1:0]  rsp_qw, rsp_qx, rsp_qy, rsp_qz,
   output logic                  rsp_degenerate
);

   localparam int ROOT_CELLS = DEF_ROOT_CELLS;
   localparam int DIV_CELLS  = DEF_DIV_CELLS;

   logic adv;
   // the chain holds as a whole; output register is last stage
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- front stage: branch select ----------------
   logic signed [RAD_W-1:0] tr, rad, d00, d11, d22;
   logic signed [DIF_W-1:0] dw, d01, d02, d12;
   logic [1:0]              sel;
   root_item_type           f_in, f_ff;
   logic                    f_valid_ff;

   always_comb begin
      d00 = RAD_W'(req_r00);
      d11 = RAD_W'(req_r11);
      d22 = RAD_W'(req_r22);
      tr  = d00 + d11 + d22;
      f_in = '0;
      dw  = '0;
      d01 = '0;
      d02 = '0;
      d12 = '0;
      if (tr > 0) begin
         sel = 2'd3;
         rad = tr + RAD_W'(Q_ONE);
         dw  = DIF_W'(req_r12) - DIF_W'(req_r21);
         d01 = DIF_W'(req_r20) - DIF_W'(req_r02);
         d02 = DIF_W'(req_r01) - DIF_W'(req_r10);
         f_in.dif = {d02, d01, dw};
      end else begin
         sel = 2'd0;
         if (d11 > d00) sel = 2'd1;
         if (d22 > ((sel == 2'd1) ? d11 : d00)) sel = 2'd2;
         case (sel)
            2'd0: begin
               rad = d00 - (d11 + d22) + RAD_W'(Q_ONE);
               dw  = DIF_W'(req_r12) - DIF_W'(req_r21);
               d01 = DIF_W'(req_r01) + DIF_W'(req_r10);  // y
               d02 = DIF_W'(req_r02) + DIF_W'(req_r20);  // z
               f_in.dif = {d02, d01, dw};                // w,y,z
            end
            2'd1: begin
               rad = d11 - (d22 + d00) + RAD_W'(Q_ONE);
               dw  = DIF_W'(req_r20) - DIF_W'(req_r02);
               d12 = DIF_W'(req_r12) + DIF_W'(req_r21);  // z
               d01 = DIF_W'(req_r10) + DIF_W'(req_r01);  // x
               f_in.dif = {d12, d01, dw};                // w,x,z
            end
            default: begin
               rad = d22 - (d00 + d11) + RAD_W'(Q_ONE);
               dw  = DIF_W'(req_r01) - DIF_W'(req_r10);
               d01 = DIF_W'(req_r20) + DIF_W'(req_r02);  // x
               d12 = DIF_W'(req_r21) + DIF_W'(req_r12);  // y
               f_in.dif = {d12, d01, dw};                // w,x,y
            end
         endcase
      end
      f_in.diag = sel;
      f_in.deg  = (rad <= 0);
      f_in.radx = f_in.deg ? '0 : {rad[2*ROOT_W-13:0], 12'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   // ---------------- square-root chain ----------------
   logic          rv [ROOT_CELLS+1];
   root_item_type ri [ROOT_CELLS+1];
   assign rv[0] = f_valid_ff;
   assign ri[0] = f_ff;

   for (genvar c = 0; c < ROOT_CELLS; c++) begin : g_root
      rmq_root_cell u_cell (
         .clock, .reset, .adv,
         .in_valid (rv[c]),   .in_item  (ri[c]),
         .out_valid(rv[c+1]), .out_item (ri[c+1])
      );
   end

   // ---------------- divide setup ----------------
   div_item_type  s_in, s_ff;
   logic          s_valid_ff;
   logic [DIF_W-1:0] mag;

   always_comb begin
      s_in = '0;
      s_in.root = ri[ROOT_CELLS].root;
      s_in.diag = ri[ROOT_CELLS].diag;
      s_in.deg  = ri[ROOT_CELLS].deg;
      mag = '0;
      for (int l = 0; l < 3; l++) begin
         s_in.neg[l] = ri[ROOT_CELLS].dif[l][DIF_W-1];
         mag = s_in.neg[l] ? (~ri[ROOT_CELLS].dif[l] + 1'b1) : ri[ROOT_CELLS].dif[l];
         // 2*mag*4096 + h, then halve quotient: round half up
         s_in.lane[l].num = NUM_W'({mag, 13'd0}) + NUM_W'(ri[ROOT_CELLS].root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff <= rv[ROOT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= s_in;
      end
   end

   // ---------------- divide chain ----------------
   logic         dv [DIV_CELLS+1];
   div_item_type di [DIV_CELLS+1];
   assign dv[0] = s_valid_ff;
   assign di[0] = s_ff;

   for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
      rmq_div_cell u_cell (
         .clock, .reset, .adv,
         .in_valid (dv[c]),   .in_item  (di[c]),
         .out_valid(dv[c+1]), .out_item (di[c+1])
      );
   end

   // ---------------- output stage ----------------
   logic [QUO_W-2:0] qm;
   logic [2:0][QW-1:0] sq;
   logic [3:0][QW-1:0] q_in;
   logic [3:0][QW-1:0] q_ff;
   logic             o_valid_ff, deg_ff;
   div_item_type     t;

   always_comb begin
      t = di[DIV_CELLS];
      qm = '0;
      for (int l = 0; l < 3; l++) begin
         qm = t.lane[l].quo[QUO_W-1:1];  // halve: (2n+h)/(2h)
         if (t.neg[l]) begin
            sq[l] = (qm > (QUO_W-1)'(32768)) ? 16'h8000 : QW'(~qm + 1'b1);
         end else begin
            sq[l] = (qm > (QUO_W-1)'(32767)) ? 16'h7fff : qm[QW-1:0];
         end
      end
      // q_in order: [3]=z [2]=y [1]=x [0]=w
      q_in = '0;
      case (t.diag)
         2'd3: q_in = {sq[2], sq[1], sq[0], QW'(t.root)};
         2'd0: q_in = {sq[2], sq[1], QW'(t.root), sq[0]};
         2'd1: q_in = {sq[2], QW'(t.root), sq[1], sq[0]};
         default: q_in = {QW'(t.root), sq[2], sq[1], sq[0]};
      endcase
      if (t.deg) q_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= dv[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff   <= q_in;
         deg_ff <= t.deg;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_qw         = q_ff[0];
   assign rsp_qx         = q_ff[1];
   assign rsp_qy         = q_ff[2];
   assign rsp_qz         = q_ff[3];
   assign rsp_degenerate = deg_ff;

endmodule

FILE: src/rmq_root_cell.sv
// ============================================================================
// rmq_root_cell: one bit of a restoring square root per cell.
// Consumes two radicand bits, yields one root bit.
// ============================================================================
module rmq_root_cell
   import rmq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  root_item_type in_item,
   output logic          out_valid,
   output root_item_type out_item
);

   logic          valid_ff, valid_in;
   root_item_type item_ff, item_in;
   logic [2*ROOT_W+1:0] trial, rem_sh;

   always_comb begin
      item_in = in_item;
      rem_sh  = {in_item.rem[2*ROOT_W-1:0], in_item.radx[2*ROOT_W-1 -: 2]};
      trial   = {{(ROOT_W){1'b0}}, in_item.root, 2'b01};
      item_in.radx = {in_item.radx[2*ROOT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         item_in.rem  = rem_sh - trial;
         item_in.root = {in_item.root[ROOT_W-2:0], 1'b1};
      end else begin
         item_in.rem  = rem_sh;
         item_in.root = {in_item.root[ROOT_W-2:0], 1'b0};
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: src/rmq_div_cell.sv
// ============================================================================
// rmq_div_cell: one quotient bit of a restoring divide per cell, for three
// lanes sharing one divisor (the half root).
// ============================================================================
module rmq_div_cell
   import rmq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  div_item_type in_item,
   output logic         out_valid,
   output div_item_type out_item
);

   logic         valid_ff;
   div_item_type item_ff, item_in;
   logic [NUM_W:0] rs;

   always_comb begin
      item_in = in_item;
      rs = '0;
      for (int l = 0; l < 3; l++) begin
         rs = {in_item.lane[l].rem[NUM_W-1:0], in_item.lane[l].num[NUM_W-1]};
         item_in.lane[l].num = {in_item.lane[l].num[NUM_W-2:0], 1'b0};
         if (rs >= {{(NUM_W+1-ROOT_W){1'b0}}, in_item.root}) begin
            item_in.lane[l].rem = rs - {{(NUM_W+1-ROOT_W){1'b0}}, in_item.root};
            item_in.lane[l].quo = {in_item.lane[l].quo[QUO_W-2:0], 1'b1};
         end else begin
            item_in.lane[l].rem = rs;
            item_in.lane[l].quo = {in_item.lane[l].quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
